FILE: rtl/date_time_text_formatter_macros.svh
// Assertion macros shared by the formatter modules.
// Every module that uses them has clk and rst in scope.
`ifndef DATE_TIME_TEXT_FORMATTER_MACROS_SVH
`define DATE_TIME_TEXT_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DTF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtf: assertion failed");
// Next-cycle implication.
`define DTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtf: assertion failed");
`else
`define DTF_ASSERT_IMPL(lbl, ante, cons)
`define DTF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/dtf_pkg.sv
package dtf_pkg;

  // Fixed field widths
  localparam int CHAR_W     = 8;
  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int SECOND_W   = 6;
  localparam int MILLI_W    = 10;
  localparam int WEEKDAY_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int COUNT_W    = 9;
  localparam int LEN_W      = 4;
  localparam int NUM_DIGITS = 5;
  localparam int DIGIT_CNT_W = 3;
  localparam int NAME_CHARS = 9;
  localparam int NAME_W     = NAME_CHARS * CHAR_W;

  // Emitted-text limit; later format bytes are dropped
  localparam logic [COUNT_W-1:0] OUT_LIMIT = 9'd250;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // Queue depth default
  localparam int QUEUE_DEPTH_DEF = 4;

  // Reciprocal of ten: (v * RECIP_10) >> RECIP_SHIFT == v / 10 for 16-bit v
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_YEAR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOUR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MILLI   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY = 3'd7;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_YEAR4   = 8'h59; // Y
  localparam logic [CHAR_W-1:0] CH_YEAR2   = 8'h79; // y
  localparam logic [CHAR_W-1:0] CH_MONTH   = 8'h6D; // m
  localparam logic [CHAR_W-1:0] CH_DAY     = 8'h64; // d
  localparam logic [CHAR_W-1:0] CH_HOUR    = 8'h48; // H
  localparam logic [CHAR_W-1:0] CH_MINUTE  = 8'h4D; // M
  localparam logic [CHAR_W-1:0] CH_SECOND  = 8'h53; // S
  localparam logic [CHAR_W-1:0] CH_MILLI   = 8'h66; // f
  localparam logic [CHAR_W-1:0] CH_WDAY_F  = 8'h41; // A
  localparam logic [CHAR_W-1:0] CH_WDAY_A  = 8'h61; // a
  localparam logic [CHAR_W-1:0] CH_MON_F   = 8'h42; // B
  localparam logic [CHAR_W-1:0] CH_MON_A   = 8'h62; // b

  typedef enum logic [1:0] {
    CMD_CHAR,   // one byte
    CMD_PCT,    // percent sign then the byte
    CMD_NUM,    // decimal number
    CMD_NAME    // weekday or month name
  } cmd_kind_t;

  typedef enum logic [1:0] {
    NAME_DAY_FULL,
    NAME_DAY_ABBR,
    NAME_MON_FULL,
    NAME_MON_ABBR
  } name_kind_t;

  // Command passed from front to back
  typedef struct packed {
    cmd_kind_t               kind;
    logic [CHAR_W-1:0]       chr;
    logic [YEAR_W-1:0]       num;
    name_kind_t              name_kind;
    logic [MONTH_W-1:0]      name_idx;
    logic [LEN_W-1:0]        len;   // body bytes, terminator not counted
    logic                    last;  // terminator follows the body
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [NAME_W-1:0] text;  // first byte in the top bits
  } name_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_BODY,
    BK_TERM
  } bk_state_t;

  // Name table: weekdays 0..6, months 0..12 (0 is empty)
  function automatic name_t name_entry(name_kind_t kind, logic [MONTH_W-1:0] idx);
    name_t e;
    e.len  = 4'd0;
    e.text = "         ";
    unique case (kind)
      NAME_DAY_FULL: begin
        unique case (idx)
          4'd0:    begin e.len = 4'd6; e.text = "Sunday   "; end
          4'd1:    begin e.len = 4'd6; e.text = "Monday   "; end
          4'd2:    begin e.len = 4'd7; e.text = "Tuesday  "; end
          4'd3:    begin e.len = 4'd9; e.text = "Wednesday"; end
          4'd4:    begin e.len = 4'd8; e.text = "Thursday "; end
          4'd5:    begin e.len = 4'd6; e.text = "Friday   "; end
          4'd6:    begin e.len = 4'd8; e.text = "Saturday "; end
          default: begin e.len = 4'd0; e.text = "         "; end
        endcase
      end
      NAME_DAY_ABBR: begin
        unique case (idx)
          4'd0:    begin e.len = 4'd3; e.text = "Sun      "; end
          4'd1:    begin e.len = 4'd3; e.text = "Mon      "; end
          4'd2:    begin e.len = 4'd3; e.text = "Tue      "; end
          4'd3:    begin e.len = 4'd3; e.text = "Wed      "; end
          4'd4:    begin e.len = 4'd3; e.text = "Thu      "; end
          4'd5:    begin e.len = 4'd3; e.text = "Fri      "; end
          4'd6:    begin e.len = 4'd3; e.text = "Sat      "; end
          default: begin e.len = 4'd0; e.text = "         "; end
        endcase
      end
      NAME_MON_FULL: begin
        unique case (idx)
          4'd1:    begin e.len = 4'd7; e.text = "January  "; end
          4'd2:    begin e.len = 4'd8; e.text = "February "; end
          4'd3:    begin e.len = 4'd5; e.text = "March    "; end
          4'd4:    begin e.len = 4'd5; e.text = "April    "; end
          4'd5:    begin e.len = 4'd3; e.text = "May      "; end
          4'd6:    begin e.len = 4'd4; e.text = "June     "; end
          4'd7:    begin e.len = 4'd4; e.text = "July     "; end
          4'd8:    begin e.len = 4'd6; e.text = "August   "; end
          4'd9:    begin e.len = 4'd9; e.text = "September"; end
          4'd10:   begin e.len = 4'd7; e.text = "October  "; end
          4'd11:   begin e.len = 4'd8; e.text = "November "; end
          4'd12:   begin e.len = 4'd8; e.text = "December "; end
          default: begin e.len = 4'd0; e.text = "         "; end
        endcase
      end
      NAME_MON_ABBR: begin
        unique case (idx)
          4'd1:    begin e.len = 4'd3; e.text = "Jan      "; end
          4'd2:    begin e.len = 4'd3; e.text = "Feb      "; end
          4'd3:    begin e.len = 4'd3; e.text = "Mar      "; end
          4'd4:    begin e.len = 4'd3; e.text = "Apr      "; end
          4'd5:    begin e.len = 4'd3; e.text = "May      "; end
          4'd6:    begin e.len = 4'd3; e.text = "Jun      "; end
          4'd7:    begin e.len = 4'd3; e.text = "Jul      "; end
          4'd8:    begin e.len = 4'd3; e.text = "Aug      "; end
          4'd9:    begin e.len = 4'd3; e.text = "Sep      "; end
          4'd10:   begin e.len = 4'd3; e.text = "Oct      "; end
          4'd11:   begin e.len = 4'd3; e.text = "Nov      "; end
          4'd12:   begin e.len = 4'd3; e.text = "Dec      "; end
          default: begin e.len = 4'd0; e.text = "         "; end
        endcase
      end
      default: begin e.len = 4'd0; e.text = "         "; end
    endcase
    return e;
  endfunction

  // Decimal digits of v, at least minw
  function automatic logic [LEN_W-1:0] num_len(logic [YEAR_W-1:0] v,
                                               logic [LEN_W-1:0] minw);
    logic [LEN_W-1:0] n;
    if (v >= 14'd10000)     n = 4'd5;
    else if (v >= 14'd1000) n = 4'd4;
    else if (v >= 14'd100)  n = 4'd3;
    else if (v >= 14'd10)   n = 4'd2;
    else                    n = 4'd1;
    return (n > minw) ? n : minw;
  endfunction

endpackage

FILE: rtl/date_time_text_formatter.sv
// Channel     | Dir | Payload                          | Handshake
// s_axis      | in  | tdata=fmt_char, tlast=fmt_last  | tvalid/tready
// m_axis      | out | tdata=text_char, tlast=run_last | tvalid/tready
//             |     | tuser=text_end                   |
// cfg         | in  | cfg_index, cfg_data              | cfg_valid/cfg_ready
//
// Literal bytes pass at one word per cycle while the output is not stalled, via
// the queue, the back end working registers and the output register. A number
// directive is converted in the divide-by-ten unit, then sent digit by digit; a
// name goes letter by letter, the terminator last. The back end sequences this.
// Reset clears the registers to zero, the queue and both sequencers.
// A stalled output holds the back end; input is taken while the queue has room.
module date_time_text_formatter #(
  parameter int QUEUE_DEPTH = dtf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] fmt_char
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] text_char
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser,  // [0] text_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic          push;
  dtf_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          q_valid;
  dtf_pkg::cmd_t q_cmd;
  logic          q_ready;

  dtf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_char    (s_axis_tdata),
    .s_last    (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  dtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (q_cmd),
    .pop_ready  (q_ready)
  );

  dtf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_ready  (q_ready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_char   (m_axis_tdata),
    .m_last   (m_axis_tlast),
    .m_end    (m_axis_tuser)
  );

endmodule

FILE: rtl/dtf_front.sv
module dtf_front (
  input  logic                            clk,
  input  logic                            rst,
  // format byte stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dtf_pkg::CHAR_W-1:0]      s_char,
  input  logic                            s_last,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // to queue
  output logic                            push,
  output dtf_pkg::cmd_t                   push_cmd,
  input  logic                            q_full
);

  logic [dtf_pkg::YEAR_W-1:0]    year_value;
  logic [dtf_pkg::MONTH_W-1:0]   month_value;
  logic [dtf_pkg::DAY_W-1:0]     day_value;
  logic [dtf_pkg::HOUR_W-1:0]    hour_value;
  logic [dtf_pkg::MINUTE_W-1:0]  minute_value;
  logic [dtf_pkg::SECOND_W-1:0]  second_value;
  logic [dtf_pkg::MILLI_W-1:0]   milli_value;
  logic [dtf_pkg::WEEKDAY_W-1:0] weekday_value;

  logic                          percent_pending, percent_pending_next;
  logic [dtf_pkg::COUNT_W-1:0]   emitted_count, emitted_count_next;

  logic                          s_fire;
  logic [dtf_pkg::MONTH_W-1:0]   month_idx;
  logic [dtf_pkg::MONTH_W-1:0]   wday_idx;
  dtf_pkg::cmd_t                 cmd;
  dtf_pkg::name_t                name;
  logic [dtf_pkg::COUNT_W:0]     count_sum;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign s_fire    = s_tvalid && s_tready;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      year_value    <= '0;
      month_value   <= '0;
      day_value     <= '0;
      hour_value    <= '0;
      minute_value  <= '0;
      second_value  <= '0;
      milli_value   <= '0;
      weekday_value <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dtf_pkg::REG_YEAR:    year_value    <= cfg_data;
        dtf_pkg::REG_MONTH:   month_value   <= cfg_data[dtf_pkg::MONTH_W-1:0];
        dtf_pkg::REG_DAY:     day_value     <= cfg_data[dtf_pkg::DAY_W-1:0];
        dtf_pkg::REG_HOUR:    hour_value    <= cfg_data[dtf_pkg::HOUR_W-1:0];
        dtf_pkg::REG_MINUTE:  minute_value  <= cfg_data[dtf_pkg::MINUTE_W-1:0];
        dtf_pkg::REG_SECOND:  second_value  <= cfg_data[dtf_pkg::SECOND_W-1:0];
        dtf_pkg::REG_MILLI:   milli_value   <= cfg_data[dtf_pkg::MILLI_W-1:0];
        dtf_pkg::REG_WEEKDAY: weekday_value <= cfg_data[dtf_pkg::WEEKDAY_W-1:0];
      endcase
    end
  end

  // Name indexes: month mod 13, weekday mod 7
  assign month_idx = (month_value >= 4'd13) ? month_value - 4'd13 : month_value;
  assign wday_idx  = (weekday_value == 3'd7) ? 4'd0 : {1'b0, weekday_value};

  // Classify the byte
  always_comb begin
    cmd           = '0;
    cmd.kind      = dtf_pkg::CMD_CHAR;
    cmd.chr       = s_char;
    cmd.num       = year_value;
    cmd.name_kind = dtf_pkg::NAME_DAY_FULL;
    cmd.name_idx  = wday_idx;
    cmd.len       = '0;
    cmd.last      = s_last;
    name          = dtf_pkg::name_entry(dtf_pkg::NAME_DAY_FULL, wday_idx);
    percent_pending_next = percent_pending;
    if (percent_pending) begin
      percent_pending_next = 1'b0;
      unique case (s_char)
        dtf_pkg::CH_YEAR4: begin
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = year_value;
          cmd.len  = dtf_pkg::num_len(year_value, 4'd4);
        end
        dtf_pkg::CH_YEAR2: begin
          // low two digits of the year are the year mod 100
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = year_value;
          cmd.len  = 4'd2;
        end
        dtf_pkg::CH_MONTH: begin
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = {10'd0, month_value};
          cmd.len  = 4'd2;
        end
        dtf_pkg::CH_DAY: begin
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = {9'd0, day_value};
          cmd.len  = 4'd2;
        end
        dtf_pkg::CH_HOUR: begin
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = {9'd0, hour_value};
          cmd.len  = 4'd2;
        end
        dtf_pkg::CH_MINUTE: begin
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = {8'd0, minute_value};
          cmd.len  = 4'd2;
        end
        dtf_pkg::CH_SECOND: begin
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = {8'd0, second_value};
          cmd.len  = 4'd2;
        end
        dtf_pkg::CH_MILLI: begin
          cmd.kind = dtf_pkg::CMD_NUM;
          cmd.num  = {4'd0, milli_value};
          cmd.len  = dtf_pkg::num_len({4'd0, milli_value}, 4'd3);
        end
        dtf_pkg::CH_WDAY_F: begin
          cmd.kind      = dtf_pkg::CMD_NAME;
          cmd.name_kind = dtf_pkg::NAME_DAY_FULL;
          cmd.name_idx  = wday_idx;
          name          = dtf_pkg::name_entry(dtf_pkg::NAME_DAY_FULL, wday_idx);
          cmd.len       = name.len;
        end
        dtf_pkg::CH_WDAY_A: begin
          cmd.kind      = dtf_pkg::CMD_NAME;
          cmd.name_kind = dtf_pkg::NAME_DAY_ABBR;
          cmd.name_idx  = wday_idx;
          name          = dtf_pkg::name_entry(dtf_pkg::NAME_DAY_ABBR, wday_idx);
          cmd.len       = name.len;
        end
        dtf_pkg::CH_MON_F: begin
          cmd.kind      = dtf_pkg::CMD_NAME;
          cmd.name_kind = dtf_pkg::NAME_MON_FULL;
          cmd.name_idx  = month_idx;
          name          = dtf_pkg::name_entry(dtf_pkg::NAME_MON_FULL, month_idx);
          cmd.len       = name.len;
        end
        dtf_pkg::CH_MON_A: begin
          cmd.kind      = dtf_pkg::CMD_NAME;
          cmd.name_kind = dtf_pkg::NAME_MON_ABBR;
          cmd.name_idx  = month_idx;
          name          = dtf_pkg::name_entry(dtf_pkg::NAME_MON_ABBR, month_idx);
          cmd.len       = name.len;
        end
        dtf_pkg::CH_PERCENT: begin
          cmd.kind = dtf_pkg::CMD_CHAR;
          cmd.len  = 4'd1;
        end
        default: begin
          // unknown directive: echo percent and the byte
          cmd.kind = dtf_pkg::CMD_PCT;
          cmd.len  = 4'd2;
        end
      endcase
    end else if (emitted_count < dtf_pkg::OUT_LIMIT) begin
      if (s_char == dtf_pkg::CH_PERCENT && !s_last) begin
        percent_pending_next = 1'b1;
      end else begin
        cmd.len = 4'd1;
      end
    end
    if (s_last) begin
      percent_pending_next = 1'b0;
    end
  end

  assign push     = s_fire && (cmd.len != '0 || s_last);
  assign push_cmd = cmd;

  // Emitted count, saturating
  always_comb begin
    count_sum = {1'b0, emitted_count} + {{(dtf_pkg::COUNT_W + 1 - dtf_pkg::LEN_W){1'b0}}, cmd.len};
    if (s_last) begin
      emitted_count_next = '0;
    end else if (count_sum > {1'b0, dtf_pkg::COUNT_MAX}) begin
      emitted_count_next = dtf_pkg::COUNT_MAX;
    end else begin
      emitted_count_next = count_sum[dtf_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
      emitted_count   <= '0;
    end else if (s_fire) begin
      percent_pending <= percent_pending_next;
      emitted_count   <= emitted_count_next;
    end
  end

endmodule

FILE: rtl/dtf_queue.sv
`include "date_time_text_formatter_macros.svh"

module dtf_queue #(
  parameter int DEPTH = dtf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtf_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output dtf_pkg::cmd_t head_cmd,
  input  logic          pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dtf_pkg::cmd_t     entry [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entry[rd_ptr];
  assign pop        = head_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DTF_ASSERT_IMPL(a_no_push_when_full, full, !push)

endmodule

FILE: rtl/dtf_back.sv
`include "date_time_text_formatter_macros.svh"

module dtf_back (
  input  logic                        clk,
  input  logic                        rst,
  // from queue
  input  logic                        q_valid,
  input  dtf_pkg::cmd_t               q_cmd,
  output logic                        q_ready,
  // text stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dtf_pkg::CHAR_W-1:0]  m_char,
  output logic                        m_last,
  output logic                        m_end
);

  dtf_pkg::bk_state_t                  state, state_next, load_state;
  dtf_pkg::cmd_t                       cmd;
  logic [dtf_pkg::LEN_W-1:0]           pos;
  logic [dtf_pkg::DIGIT_CNT_W-1:0]     cnt;
  logic [dtf_pkg::YEAR_W-1:0]          val;
  logic [4*dtf_pkg::NUM_DIGITS-1:0]    dig;

  logic                                out_free;
  logic                                body_end;
  logic                                conv_end;
  logic                                emit;
  logic [dtf_pkg::CHAR_W-1:0]          item_char;
  logic                                item_last;
  logic                                item_end;

  logic [dtf_pkg::YEAR_W+15:0]         prod;
  logic [dtf_pkg::YEAR_W-1:0]          quot;
  logic [dtf_pkg::YEAR_W-1:0]          rem;
  dtf_pkg::name_t                      name;
  logic [dtf_pkg::NAME_W-1:0]          name_sh;

  assign out_free = !m_tvalid || m_tready;
  assign body_end = (pos == cmd.len - 4'd1);
  assign conv_end = ({1'b0, cnt} == cmd.len - 4'd1);

  // State on loading a new word from the queue
  always_comb begin
    if (q_cmd.len == '0) begin
      load_state = dtf_pkg::BK_TERM;
    end else if (q_cmd.kind == dtf_pkg::CMD_NUM) begin
      load_state = dtf_pkg::BK_CONV;
    end else begin
      load_state = dtf_pkg::BK_BODY;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dtf_pkg::BK_IDLE: begin
        if (q_valid) state_next = load_state;
      end
      dtf_pkg::BK_CONV: begin
        if (conv_end) state_next = dtf_pkg::BK_BODY;
      end
      dtf_pkg::BK_BODY: begin
        if (out_free && body_end) begin
          if (cmd.last)     state_next = dtf_pkg::BK_TERM;
          else if (q_valid) state_next = load_state;
          else              state_next = dtf_pkg::BK_IDLE;
        end
      end
      dtf_pkg::BK_TERM: begin
        if (out_free) state_next = q_valid ? load_state : dtf_pkg::BK_IDLE;
      end
      default: state_next = dtf_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    name    = dtf_pkg::name_entry(cmd.name_kind, cmd.name_idx);
    name_sh = name.text << {pos, 3'b000};
    q_ready   = 1'b0;
    emit      = 1'b0;
    item_char = dtf_pkg::CH_NUL;
    item_last = 1'b0;
    item_end  = 1'b0;
    unique case (state)
      dtf_pkg::BK_IDLE: begin
        q_ready = 1'b1;
      end
      dtf_pkg::BK_CONV: begin
        q_ready = 1'b0;
      end
      dtf_pkg::BK_BODY: begin
        emit      = out_free;
        q_ready   = out_free && body_end && !cmd.last;
        item_last = body_end && !cmd.last;
        unique case (cmd.kind)
          dtf_pkg::CMD_CHAR: item_char = cmd.chr;
          dtf_pkg::CMD_PCT:  item_char = (pos == '0) ? dtf_pkg::CH_PERCENT : cmd.chr;
          dtf_pkg::CMD_NUM:  item_char = dtf_pkg::CH_ZERO + {4'd0, dig[3:0]};
          dtf_pkg::CMD_NAME: item_char = name_sh[dtf_pkg::NAME_W-1 -: dtf_pkg::CHAR_W];
          default:           item_char = cmd.chr;
        endcase
      end
      dtf_pkg::BK_TERM: begin
        emit      = out_free;
        q_ready   = out_free;
        item_char = dtf_pkg::CH_NUL;
        item_last = 1'b1;
        item_end  = 1'b1;
      end
      default: q_ready = 1'b0;
    endcase
  end

  // One decimal digit per cycle, least significant first
  assign prod = {16'd0, val} * {{dtf_pkg::YEAR_W{1'b0}}, dtf_pkg::RECIP_10};
  assign quot = {{(dtf_pkg::RECIP_SHIFT - 16){1'b0}},
                 prod[dtf_pkg::YEAR_W+15:dtf_pkg::RECIP_SHIFT]};
  assign rem  = val - {quot[dtf_pkg::YEAR_W-4:0], 3'b000} - {quot[dtf_pkg::YEAR_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cmd <= q_cmd;
      pos <= '0;
      cnt <= '0;
      val <= q_cmd.num;
    end else if (state == dtf_pkg::BK_CONV) begin
      // newest digit at the bottom, so the top digit comes out first
      val <= quot;
      dig <= {dig[4*dtf_pkg::NUM_DIGITS-5:0], rem[3:0]};
      cnt <= cnt + 1'b1;
    end else if (state == dtf_pkg::BK_BODY && out_free) begin
      pos <= pos + 1'b1;
      dig <= {4'd0, dig[4*dtf_pkg::NUM_DIGITS-1:4]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_char <= item_char;
      m_last <= item_last;
      m_end  <= item_end;
    end
  end

  `DTF_ASSERT_IMPL(a_conv_is_num, state == dtf_pkg::BK_CONV, cmd.kind == dtf_pkg::CMD_NUM)
  `DTF_ASSERT_IMPL(a_body_in_range, state == dtf_pkg::BK_BODY, pos < cmd.len)
  `DTF_ASSERT_IMPL(a_term_needs_last, state == dtf_pkg::BK_TERM, cmd.last)
  `DTF_ASSERT_NEXT(a_conv_to_body, state == dtf_pkg::BK_CONV && conv_end, state == dtf_pkg::BK_BODY)
  `DTF_ASSERT_IMPL(a_end_is_last, m_tvalid && m_end, m_last)

endmodule
